// File: rtl/core/dq_pkg.sv
`default_nettype none
package dq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OP_W  = 3;
   localparam int POS_W = 5;
   localparam int ST_W  = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd4;
   localparam logic [OP_W-1:0] OP_LIST_ALL   = 3'd5;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [VAL_W-1:0] val_type;

endpackage
`default_nettype wire

// File: rtl/core/bounded_deque_with_insert.sv
`default_nettype none
// Ring-buffer deque of up to 16 signed 32-bit words with push/pop at both ends,
// insert at a 1-based position and a list-all dump from front to back. One
// request is taken at a time: req_ready is high only while the sequencer idles.
// Push, pop and rejected requests pass through S_EXEC and then S_STAT, which loads
// the status word. Insert at position p with n stored words moves the words behind
// p back one per cycle through the ring RAM and the shared slot adder, then writes
// the new word; insert at the back (p = n + 1) moves no words.
// List all reads each word from the RAM, then loads it into the output register.
// Every result waits in an output register until rsp_ready takes it.
module bounded_deque_with_insert (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [dq_pkg::OP_W-1:0]     req_opcode,
   input  wire logic signed [dq_pkg::VAL_W-1:0] req_item_value,
   input  wire logic [dq_pkg::POS_W-1:0]    req_position,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [dq_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                             rsp_last_of_run,
   output logic [dq_pkg::ST_W-1:0]          rsp_status,
   output logic [dq_pkg::CNT_W-1:0]         rsp_entry_count
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_STAT     = 4'd2;
   localparam logic [3:0] S_SH_INIT  = 4'd3;
   localparam logic [3:0] S_SHIFT    = 4'd4;
   localparam logic [3:0] S_DRAIN    = 4'd5;
   localparam logic [3:0] S_PLACE    = 4'd6;
   localparam logic [3:0] S_LIST_RD  = 4'd7;
   localparam logic [3:0] S_LIST_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   dq_pkg::idx_type head_ff, head_in;
   dq_pkg::cnt_type count_ff, count_in;
   dq_pkg::cnt_type i_ff, i_in;
   dq_pkg::idx_type last_ff, last_in;
   dq_pkg::idx_type tgt_ff, tgt_in;
   logic pend_ff, pend_in;
   logic [dq_pkg::OP_W-1:0] op_ff, op_in;
   dq_pkg::val_type val_ff, val_in;
   logic [dq_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [dq_pkg::ST_W-1:0] st_ff, st_in;

   logic rsp_valid_ff, rsp_valid_in;
   dq_pkg::val_type out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;
   logic [dq_pkg::ST_W-1:0] out_status_ff, out_status_in;
   dq_pkg::cnt_type out_count_ff, out_count_in;

   dq_pkg::idx_type ofs;
   dq_pkg::idx_type slot;
   dq_pkg::cnt_type i_dec;
   dq_pkg::cnt_type i_inc;
   logic out_free;
   logic full;
   logic wr_en, rd_en;
   dq_pkg::idx_type wr_addr, rd_addr;
   dq_pkg::val_type wr_data, rd_data;

   dq_slot u_slot (
      .head   (head_ff),
      .offset (ofs),
      .slot   (slot)
   );

   dq_ram #(
      .WIDTH (dq_pkg::VAL_W),
      .DEPTH (dq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = count_ff >= dq_pkg::CNT_W'(dq_pkg::DEPTH);
   assign i_dec    = i_ff - dq_pkg::CNT_W'(1);
   assign i_inc    = i_ff + dq_pkg::CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      last_in       = last_ff;
      tgt_in        = tgt_ff;
      pend_in       = pend_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      ofs           = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               val_in   = req_item_value;
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in    = dq_pkg::ST_OK;
            state_in = S_STAT;
            case (op_ff)
               dq_pkg::OP_PUSH_FRONT: begin
                  ofs = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
                  if (full) begin
                     st_in = dq_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot;
                     wr_data  = val_ff;
                     head_in  = slot;
                     count_in = count_ff + dq_pkg::CNT_W'(1);
                  end
               end
               dq_pkg::OP_PUSH_BACK: begin
                  ofs = count_ff[dq_pkg::IDX_W-1:0];
                  if (full) begin
                     st_in = dq_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot;
                     wr_data  = val_ff;
                     count_in = count_ff + dq_pkg::CNT_W'(1);
                  end
               end
               dq_pkg::OP_POP_FRONT: begin
                  ofs = dq_pkg::IDX_W'(1);
                  if (count_ff == '0) begin
                     st_in = dq_pkg::ST_EMPTY;
                  end else begin
                     head_in  = slot;
                     count_in = count_ff - dq_pkg::CNT_W'(1);
                  end
               end
               dq_pkg::OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     st_in = dq_pkg::ST_EMPTY;
                  end else begin
                     count_in = count_ff - dq_pkg::CNT_W'(1);
                  end
               end
               dq_pkg::OP_INSERT_AT: begin
                  if (full) begin
                     st_in = dq_pkg::ST_FULL;
                  end else if (pos_ff == '0 ||
                               {1'b0, pos_ff} > ({1'b0, count_ff} + 6'd1)) begin
                     st_in = dq_pkg::ST_BADPOS;
                  end else begin
                     state_in = S_SH_INIT;
                  end
               end
               dq_pkg::OP_LIST_ALL: begin
                  if (count_ff == '0) begin
                     st_in = dq_pkg::ST_EMPTY;
                  end else begin
                     i_in     = '0;
                     state_in = S_LIST_RD;
                  end
               end
               default: begin
                  st_in = dq_pkg::ST_OK;
               end
            endcase
         end
         S_STAT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_value_in  = '0;
               out_last_in   = 1'b1;
               out_status_in = st_ff;
               out_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         S_SH_INIT: begin
            ofs     = count_ff[dq_pkg::IDX_W-1:0];
            last_in = slot;
            i_in    = count_ff;
            pend_in = 1'b0;
            if (count_ff >= pos_ff) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SHIFT: begin
            // read slot i-1 while the word read last cycle lands one step back
            ofs     = i_dec[dq_pkg::IDX_W-1:0];
            rd_en   = 1'b1;
            rd_addr = slot;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = tgt_ff;
               wr_data = rd_data;
            end
            tgt_in  = last_ff;
            last_in = slot;
            pend_in = 1'b1;
            i_in    = i_dec;
            if (i_ff == pos_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_data  = rd_data;
            state_in = S_PLACE;
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = last_ff;
            wr_data  = val_ff;
            count_in = count_ff + dq_pkg::CNT_W'(1);
            st_in    = dq_pkg::ST_OK;
            state_in = S_STAT;
         end
         S_LIST_RD: begin
            ofs      = i_ff[dq_pkg::IDX_W-1:0];
            rd_en    = 1'b1;
            rd_addr  = slot;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_value_in  = rd_data;
               out_last_in   = (i_inc == count_ff);
               out_status_in = dq_pkg::ST_OK;
               out_count_in  = count_ff;
               if (i_inc == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_inc;
                  state_in = S_LIST_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      last_ff       <= last_in;
      tgt_ff        <= tgt_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      st_ff         <= st_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = $signed(out_value_ff);
   assign rsp_last_of_run = out_last_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("entry count above depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in progress");

   a_ram_no_collide: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("shift reads the slot it writes");

   a_list_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST_OUT && out_free) |=> (rsp_valid && rsp_status == dq_pkg::ST_OK))
      else $error("list word without ok status");

endmodule
`default_nettype wire

// File: rtl/core/dq_ram.sv
`default_nettype none
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/dq_slot.sv
`default_nettype none
module dq_slot (
   input  wire dq_pkg::idx_type head,
   input  wire dq_pkg::idx_type offset,
   output dq_pkg::idx_type      slot
);

   logic [dq_pkg::IDX_W:0] sum;

   // ring wrap by one compare and subtract
   always_comb begin
      sum = {1'b0, head} + {1'b0, offset};
      if (sum >= (dq_pkg::IDX_W + 1)'(dq_pkg::DEPTH)) begin
         sum = sum - (dq_pkg::IDX_W + 1)'(dq_pkg::DEPTH);
      end
      slot = sum[dq_pkg::IDX_W-1:0];
   end

endmodule
`default_nettype wire

// File: bench/dq_checker.sv
`timescale 1ns / 1ps
module dq_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [dq_pkg::OP_W-1:0]         req_opcode,
   input  wire logic signed [dq_pkg::VAL_W-1:0] req_item_value,
   input  wire logic [dq_pkg::POS_W-1:0]        req_position,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic signed [dq_pkg::VAL_W-1:0] rsp_out_value,
   input  wire logic                            rsp_last_of_run,
   input  wire logic [dq_pkg::ST_W-1:0]         rsp_status,
   input  wire logic [dq_pkg::CNT_W-1:0]        rsp_entry_count,
   output int                                   error_count,
   output int                                   awaited,
   output int                                   words_checked,
   output int                                   full_seen,
   output int                                   empty_seen,
   output int                                   badpos_seen
);

   typedef struct {
      dq_pkg::val_type         value;
      logic                    last;
      logic [dq_pkg::ST_W-1:0] status;
      dq_pkg::cnt_type         count;
   } rsp_word_type;

   rsp_word_type    pending_words[$];
   dq_pkg::val_type ring [dq_pkg::DEPTH];
   int              front;
   int              level;
   int              errors;
   int              words;
   int              fulls;
   int              empties;
   int              badposes;

   function automatic int slot(int offset);
      return (front + offset) % dq_pkg::DEPTH;
   endfunction

   function automatic void add_word(dq_pkg::val_type value, logic last,
                                    logic [dq_pkg::ST_W-1:0] status);
      rsp_word_type w;
      w.value  = value;
      w.last   = last;
      w.status = status;
      w.count  = dq_pkg::cnt_type'(level);
      pending_words.push_back(w);
   endfunction

   function automatic void update_deque(logic [dq_pkg::OP_W-1:0] op, dq_pkg::val_type value,
                                        logic [dq_pkg::POS_W-1:0] pos);
      int i;
      case (op)
         dq_pkg::OP_PUSH_FRONT: begin
            if (level >= dq_pkg::DEPTH) begin
               add_word('0, 1'b1, dq_pkg::ST_FULL);
            end else begin
               front = (front + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
               ring[front] = value;
               level++;
               add_word('0, 1'b1, dq_pkg::ST_OK);
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (level >= dq_pkg::DEPTH) begin
               add_word('0, 1'b1, dq_pkg::ST_FULL);
            end else begin
               ring[slot(level)] = value;
               level++;
               add_word('0, 1'b1, dq_pkg::ST_OK);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (level == 0) begin
               add_word('0, 1'b1, dq_pkg::ST_EMPTY);
            end else begin
               front = (front + 1) % dq_pkg::DEPTH;
               level--;
               add_word('0, 1'b1, dq_pkg::ST_OK);
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (level == 0) begin
               add_word('0, 1'b1, dq_pkg::ST_EMPTY);
            end else begin
               level--;
               add_word('0, 1'b1, dq_pkg::ST_OK);
            end
         end
         dq_pkg::OP_INSERT_AT: begin
            if (level >= dq_pkg::DEPTH) begin
               add_word('0, 1'b1, dq_pkg::ST_FULL);
            end else if (pos < 1 || int'(pos) > level + 1) begin
               add_word('0, 1'b1, dq_pkg::ST_BADPOS);
            end else begin
               // words behind the insert point move one slot toward the back
               for (i = level; i > int'(pos) - 1; i--)
                  ring[slot(i)] = ring[slot(i - 1)];
               ring[slot(int'(pos) - 1)] = value;
               level++;
               add_word('0, 1'b1, dq_pkg::ST_OK);
            end
         end
         dq_pkg::OP_LIST_ALL: begin
            if (level == 0) begin
               add_word('0, 1'b1, dq_pkg::ST_EMPTY);
            end else begin
               for (i = 0; i < level; i++)
                  add_word(ring[slot(i)], i == level - 1, dq_pkg::ST_OK);
            end
         end
         default: add_word('0, 1'b1, dq_pkg::ST_OK);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         pending_words.delete();
         front    = 0;
         level    = 0;
         errors   = 0;
         words    = 0;
         fulls    = 0;
         empties  = 0;
         badposes = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("unexpected response word: out_value %0d, status %0d",
                      rsp_out_value, rsp_status);
               errors++;
            end else begin
               want = pending_words.pop_front();
               words++;
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", $signed(want.value),
                         rsp_out_value);
                  errors++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  errors++;
               end
               case (want.status)
                  dq_pkg::ST_FULL:   fulls++;
                  dq_pkg::ST_EMPTY:  empties++;
                  dq_pkg::ST_BADPOS: badposes++;
                  default:           ;
               endcase
            end
         end
         if (req_valid && req_ready)
            update_deque(req_opcode, req_item_value, req_position);
      end
      error_count   <= errors;
      awaited       <= pending_words.size();
      words_checked <= words;
      full_seen     <= fulls;
      empty_seen    <= empties;
      badpos_seen   <= badposes;
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int RANDOM_ITEMS   = 140;
   localparam int STALL_MAX      = 18;
   localparam int HOLD_OFF       = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;
   localparam int MODE_NOISE = 3;

   localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   wire                             req_ready;
   logic [dq_pkg::OP_W-1:0]         req_opcode     = '0;
   logic signed [dq_pkg::VAL_W-1:0] req_item_value = '0;
   logic [dq_pkg::POS_W-1:0]        req_position   = '0;
   wire                             rsp_valid;
   logic                            rsp_ready      = 1'b0;
   wire signed [dq_pkg::VAL_W-1:0]  rsp_out_value;
   wire                             rsp_last_of_run;
   wire [dq_pkg::ST_W-1:0]          rsp_status;
   wire [dq_pkg::CNT_W-1:0]         rsp_entry_count;

   int error_count;
   int awaited;
   int words_checked;
   int full_seen;
   int empty_seen;
   int badpos_seen;

   int depth_now   = 0;
   int sent        = 0;
   int random_sent = 0;
   int idle_run    = 0;
   bit tx_burst    = 1'b0;

   bounded_deque_with_insert u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   dq_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .error_count     (error_count),
      .awaited         (awaited),
      .words_checked   (words_checked),
      .full_seen       (full_seen),
      .empty_seen      (empty_seen),
      .badpos_seen     (badpos_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   task automatic send_request(input logic [dq_pkg::OP_W-1:0] op,
                               input logic [dq_pkg::VAL_W-1:0] value,
                               input logic [dq_pkg::POS_W-1:0] pos);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_item_value <= value;
      req_position   <= pos;
      do @(posedge clock); while (!req_ready);
      sent++;
      // occupancy only, to steer insert positions
      case (op)
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
            if (depth_now < dq_pkg::DEPTH) depth_now++;
         dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
            if (depth_now > 0) depth_now--;
         dq_pkg::OP_INSERT_AT:
            if (depth_now < dq_pkg::DEPTH && pos >= 1 && int'(pos) <= depth_now + 1)
               depth_now++;
         default: ;
      endcase
   endtask

   function automatic logic [dq_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [dq_pkg::POS_W-1:0] pick_position(bit in_range);
      if (in_range && depth_now < dq_pkg::DEPTH)
         return dq_pkg::POS_W'($urandom_range(1, depth_now + 1));
      if ($urandom_range(0, 1) == 0 || depth_now + 2 > 31)
         return '0;
      return dq_pkg::POS_W'($urandom_range(depth_now + 2, 31));
   endfunction

   function automatic logic [dq_pkg::OP_W-1:0] pick_opcode(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:
            return r < 40 ? dq_pkg::OP_PUSH_FRONT :
                   r < 70 ? dq_pkg::OP_PUSH_BACK :
                   r < 95 ? dq_pkg::OP_INSERT_AT : dq_pkg::OP_LIST_ALL;
         MODE_DRAIN:
            return r < 40 ? dq_pkg::OP_POP_FRONT :
                   r < 80 ? dq_pkg::OP_POP_BACK :
                   r < 90 ? dq_pkg::OP_LIST_ALL : dq_pkg::OP_PUSH_BACK;
         MODE_MIXED: return dq_pkg::OP_W'($urandom_range(0, 5));
         default:    return dq_pkg::OP_W'($urandom_range(0, 7));
      endcase
   endfunction

   // response side: random stalls, bursts, and two long hold-offs
   initial begin
      int stall;
      int taken;
      bit rx_burst;
      taken    = 0;
      rx_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
         if (taken == 30 || taken == 150) stall = HOLD_OFF;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      logic [dq_pkg::OP_W-1:0] op;
      int mode;
      int len;
      bit in_range;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty store corners
      send_request(dq_pkg::OP_LIST_ALL,   '0, '0);
      send_request(dq_pkg::OP_POP_FRONT,  '0, '0);
      send_request(dq_pkg::OP_POP_BACK,   '0, '1);
      send_request(dq_pkg::OP_INSERT_AT,  '1, 5'd0);
      send_request(dq_pkg::OP_INSERT_AT,  '1, 5'd2);
      send_request(dq_pkg::OP_INSERT_AT,  '1, 5'd31);
      // insert at front, middle and back, push both ends
      send_request(dq_pkg::OP_INSERT_AT,  32'h7fff_ffff, 5'd1);
      send_request(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, '0);
      send_request(dq_pkg::OP_INSERT_AT,  32'hffff_ffff, 5'd3);
      send_request(dq_pkg::OP_INSERT_AT,  32'h5555_5555, 5'd2);
      send_request(dq_pkg::OP_PUSH_BACK,  32'haaaa_aaaa, '1);
      send_request(dq_pkg::OP_LIST_ALL,   '0, '0);
      send_request(OP_UNUSED_6,           '1, '1);
      send_request(OP_UNUSED_7,           '0, '0);
      send_request(dq_pkg::OP_POP_FRONT,  '0, '0);
      send_request(dq_pkg::OP_POP_BACK,   '0, '0);
      send_request(dq_pkg::OP_LIST_ALL,   '0, '0);
      send_request(dq_pkg::OP_POP_BACK,   '0, '0);
      send_request(dq_pkg::OP_POP_FRONT,  '0, '0);
      // single word left
      send_request(dq_pkg::OP_POP_FRONT,  '0, '0);
      send_request(dq_pkg::OP_LIST_ALL,   '0, '0);
      send_request(dq_pkg::OP_POP_BACK,   '0, '0);

      while (random_sent < RANDOM_ITEMS) begin
         mode     = $urandom_range(MODE_FILL, MODE_NOISE);
         len      = $urandom_range(4, 24);
         tx_burst = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            op       = pick_opcode(mode);
            in_range = (mode != MODE_NOISE) && ($urandom_range(0, 9) != 0);
            send_request(op, pick_value(),
                         op == dq_pkg::OP_INSERT_AT ? pick_position(in_range) :
                                                      dq_pkg::POS_W'($urandom));
            if (op <= dq_pkg::OP_LIST_ALL) random_sent++;
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests driven (%0d random), %0d response words checked",
               sent, random_sent, words_checked);
      $display("rejections seen: %0d full, %0d empty, %0d bad position",
               full_seen, empty_seen, badpos_seen);
      if (error_count == 0 && awaited == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
